FILE: hdl/fsa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the free list slot allocator
package fsa_pkg;

    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int OFS_W   = 22;
    localparam int STAT_W  = 2;
    localparam int BYTES_W = 13;
    localparam int COUNT_W = 11;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic REG_SLOT_BYTES = 1'b0;
    localparam logic REG_SLOT_COUNT = 1'b1;

    localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = 13'd8;
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic accept;
        logic execute;
        logic sweep_load;
        logic sweep_step;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_dp_stat;

endpackage

FILE: hdl/fsa_regs.sv
`timescale 1ns / 1ps
// apb configuration registers: slot size and slot count
module fsa_regs
    import fsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [BYTES_W-1:0] o_slot_bytes,
    output logic [COUNT_W-1:0] o_slot_count
);

    logic [BYTES_W-1:0] r_slot_bytes;
    logic [COUNT_W-1:0] r_slot_count;
    logic               w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_bytes <= SLOT_BYTES_RST;
            r_slot_count <= SLOT_COUNT_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SLOT_BYTES: r_slot_bytes <= pwdata[BYTES_W-1:0];
                REG_SLOT_COUNT: r_slot_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SLOT_BYTES: prdata = DATA_W'(r_slot_bytes);
            REG_SLOT_COUNT: prdata = DATA_W'(r_slot_count);
            default:        prdata = '0;
        endcase
    end

    assign o_slot_bytes = r_slot_bytes;
    assign o_slot_count = r_slot_count;

endmodule

FILE: hdl/fsa_ctrl.sv
`timescale 1ns / 1ps
// controller: request sequencing and free list rebuild sweep
module fsa_ctrl
    import fsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FUNC_W-1:0] i_func,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SWEEP,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;
    logic   r_report;
    logic   w_accept;

    assign w_accept = (r_state == S_IDLE) && i_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_busy   <= 1'b1;
            r_done   <= 1'b0;
            r_report <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_busy <= 1'b1;
                        if (i_func == FUNC_REINIT) begin
                            r_state  <= S_LOAD;
                            r_report <= 1'b1;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
                S_LOAD: begin
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (i_stat.sweep_last) begin
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                        r_done   <= r_report;
                        r_report <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.accept     = w_accept;
        o_cmd.execute    = (r_state == S_EXEC);
        o_cmd.sweep_load = (r_state == S_LOAD);
        o_cmd.sweep_step = (r_state == S_SWEEP);
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

FILE: hdl/fsa_dp.sv
`timescale 1ns / 1ps
// datapath: next-slot memory, list head, rebuild counter and result registers
module fsa_dp
    import fsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [SLOT_W-1:0]  i_release_slot,
    input  logic [BYTES_W-1:0] i_slot_bytes,
    input  logic [COUNT_W-1:0] i_slot_count,
    output t_dp_stat           o_stat,
    output logic [SLOT_W-1:0]  o_granted_slot,
    output logic [OFS_W-1:0]   o_byte_offset,
    output logic [STAT_W-1:0]  o_status
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW = AW + 1;
    localparam int CW = (PW > COUNT_W) ? PW : COUNT_W;
    localparam int RW = (PW > SLOT_W) ? PW : SLOT_W;
    localparam logic [PW-1:0] END_MARK = PW'(MAX_SLOTS);
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_SLOTS);

    logic [PW-1:0]     mem [MAX_SLOTS];
    logic [PW-1:0]     r_head;
    logic [PW-1:0]     r_active;
    logic [PW-1:0]     r_idx;
    logic [PW-1:0]     r_rd;
    logic [FUNC_W-1:0] r_func;
    logic              r_rel_ok;
    logic [SLOT_W-1:0] r_granted;
    logic [OFS_W-1:0]  r_offset;
    logic [STAT_W-1:0] r_status;

    logic [CW-1:0]     w_count_x;
    logic [PW-1:0]     w_clamped;
    logic [PW-1:0]     w_idx_next;
    logic              w_active_zero;
    logic              w_sweep_last;
    logic              w_head_ok;
    logic [RW-1:0]     w_rel_x;
    logic              w_rel_ok;
    logic              w_free_wr;
    logic              w_sweep_wr;
    logic [OFS_W-1:0]  w_prod;

    assign w_count_x     = CW'(i_slot_count);
    assign w_clamped     = (w_count_x > MAX_C) ? END_MARK : PW'(w_count_x);
    assign w_idx_next    = r_idx + PW'(1);
    assign w_active_zero = (r_active == '0);
    assign w_sweep_last  = w_active_zero || (w_idx_next == r_active);
    assign w_head_ok     = (r_head < END_MARK);
    assign w_rel_x       = RW'(i_release_slot);
    assign w_rel_ok      = (w_rel_x < RW'(r_active));
    assign w_free_wr     = i_cmd.accept && (i_func == FUNC_FREE) && w_rel_ok;
    assign w_sweep_wr    = i_cmd.sweep_step && !w_active_zero;
    assign w_prod        = OFS_W'(r_head) * OFS_W'(i_slot_bytes);

    assign o_stat.sweep_last = w_sweep_last;

    always_ff @(posedge i_clk) begin
        if (w_sweep_wr) begin
            mem[r_idx[AW-1:0]] <= w_sweep_last ? END_MARK : w_idx_next;
        end else if (w_free_wr) begin
            mem[w_rel_x[AW-1:0]] <= r_head;
        end
        if (i_cmd.accept && w_head_ok) begin
            r_rd <= mem[r_head[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func   <= i_func;
            r_rel_ok <= w_rel_ok;
            if (w_free_wr) begin
                r_head <= PW'(w_rel_x);
            end
        end
        if (i_cmd.sweep_load) begin
            r_active <= w_clamped;
            r_idx    <= '0;
        end
        if (i_cmd.sweep_step) begin
            r_idx <= w_idx_next;
            if (w_sweep_last) begin
                r_head    <= w_active_zero ? END_MARK : '0;
                r_granted <= '0;
                r_offset  <= '0;
                r_status  <= ST_OK;
            end
        end
        if (i_cmd.execute) begin
            r_granted <= '0;
            r_offset  <= '0;
            r_status  <= ST_OK;
            case (r_func)
                FUNC_ALLOC: begin
                    if (w_head_ok) begin
                        r_head    <= r_rd;
                        r_granted <= SLOT_W'(r_head);
                        r_offset  <= w_prod;
                    end else begin
                        r_status <= ST_EMPTY;
                    end
                end
                FUNC_FREE: begin
                    if (!r_rel_ok) begin
                        r_status <= ST_RANGE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_granted_slot = r_granted;
    assign o_byte_offset  = r_offset;
    assign o_status       = r_status;

endmodule

FILE: hdl/free_list_slot_allocator_unit.sv
`timescale 1ns / 1ps
// top level of the free list slot allocator
//
// a request is taken when start is high and busy is low: i_func selects
// alloc, free (of i_release_slot) or reinit of the free list.
// every request gives one result on o_granted_slot, o_byte_offset and
// o_status, shown for one cycle while o_done is high; the receiver
// cannot hold it off.
// alloc, free and the unused code: the accept cycle reads the next-slot
// entry of the head from the synchronous memory (a valid free also links
// the released slot in as the new head there), the execute state then
// updates the head of an alloc and registers the result; o_done is high in
// the cycle after that, when busy is already low and a new request can be
// taken. reinit rebuilds the chain one memory entry a cycle (slot_count
// clamped to MAX_SLOTS). after reset the same rebuild runs with slot_count
// 1024 clamped to MAX_SLOTS, busy high until it ends, no result given.
// slot_bytes and slot_count are written over the apb port at 0x0 and 0x4;
// the user must write them only while the block is idle, which the block
// itself does not enforce; slot_count takes effect at the next reinit.
module free_list_slot_allocator_unit
    import fsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [SLOT_W-1:0]  i_release_slot,
    output logic               o_done,
    output logic [SLOT_W-1:0]  o_granted_slot,
    output logic [OFS_W-1:0]   o_byte_offset,
    output logic [STAT_W-1:0]  o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [BYTES_W-1:0] w_slot_bytes;
    logic [COUNT_W-1:0] w_slot_count;

    fsa_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_slot_bytes (w_slot_bytes),
        .o_slot_count (w_slot_count)
    );

    fsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    fsa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_func         (i_func),
        .i_release_slot (i_release_slot),
        .i_slot_bytes   (w_slot_bytes),
        .i_slot_count   (w_slot_count),
        .o_stat         (w_stat),
        .o_granted_slot (o_granted_slot),
        .o_byte_offset  (o_byte_offset),
        .o_status       (o_status)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted request");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && !w_cmd.execute && !w_cmd.sweep_step)
        else $error("result strobe while request still in progress");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> (o_granted_slot == '0) && (o_byte_offset == '0))
        else $error("nonzero slot on failed request");

endmodule

FILE: verif/tb_free_list_slot_allocator_unit.sv
`timescale 1ns / 1ps
// self-checking testbench of the free list slot allocator: predicted alloc/free/reinit results
module tb_free_list_slot_allocator_unit;
    import fsa_pkg::*;

    localparam int MAX_SLOTS = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_REQS = 2000;
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_SLOT_BYTES = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_SLOT_COUNT = 3'd4;
    localparam logic [COUNT_W-1:0] END_MARK = COUNT_W'(MAX_SLOTS);

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
    } t_alloc_req;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [OFS_W-1:0]  offset;
        logic [STAT_W-1:0] status;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [FUNC_W-1:0] i_func = '0;
    logic [SLOT_W-1:0] i_release_slot = '0;
    logic o_done;
    logic [SLOT_W-1:0] o_granted_slot;
    logic [OFS_W-1:0] o_byte_offset;
    logic [STAT_W-1:0] o_status;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    t_alloc_req pending_reqs[$];
    t_grant expected_grants[$];

    logic [COUNT_W-1:0] chain_next [MAX_SLOTS];
    logic [COUNT_W-1:0] pool_head;
    int unsigned pool_size;
    logic [BYTES_W-1:0] cfg_bytes;
    logic [COUNT_W-1:0] cfg_count;

    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned random_sent = 0;
    int unsigned gap_left = 0;
    bit gap_mode = 1'b0;
    logic req_taken = 1'b0;
    t_alloc_req drv_req;

    free_list_slot_allocator_unit #(
        .MAX_SLOTS(MAX_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_release_slot(i_release_slot),
        .o_done(o_done),
        .o_granted_slot(o_granted_slot),
        .o_byte_offset(o_byte_offset),
        .o_status(o_status),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic void rebuild_pool();
        pool_size = (cfg_count > MAX_SLOTS) ? MAX_SLOTS : cfg_count;
        if (pool_size == 0) begin
            pool_head = END_MARK;
        end else begin
            for (int i = 0; i + 1 < pool_size; i++) begin
                chain_next[i] = COUNT_W'(i + 1);
            end
            chain_next[pool_size - 1] = END_MARK;
            pool_head = '0;
        end
    endfunction

    function automatic void predict_grant(input logic [FUNC_W-1:0] func,
                                          input logic [SLOT_W-1:0] rel);
        t_grant g;
        logic [31:0] prod;
        g.slot = '0;
        g.offset = '0;
        g.status = ST_OK;
        case (func)
            FUNC_ALLOC: begin
                if (pool_head >= MAX_SLOTS) begin
                    g.status = ST_EMPTY;
                end else begin
                    g.slot = pool_head[SLOT_W-1:0];
                    pool_head = chain_next[g.slot];
                    prod = 32'(g.slot) * 32'(cfg_bytes);
                    g.offset = prod[OFS_W-1:0];
                end
            end
            FUNC_FREE: begin
                if (rel >= pool_size) begin
                    g.status = ST_RANGE;
                end else begin
                    chain_next[rel] = pool_head;
                    pool_head = COUNT_W'(rel);
                end
            end
            FUNC_REINIT: begin
                rebuild_pool();
            end
            default: begin
            end
        endcase
        expected_grants.push_back(g);
    endfunction

    task automatic note_mismatch(input string field, input int unsigned exp_val,
                                 input int unsigned act_val);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch in %s: expected %0d, got %0d", field, exp_val, act_val);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gap_mode || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                start <= 1'b0;
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end
            end else begin
                drv_req = pending_reqs.pop_front();
                start <= 1'b1;
                i_func <= drv_req.func;
                i_release_slot <= drv_req.slot;
                gap_left = pick_gap();
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_grant g;
        req_taken <= start && !busy && i_rst_n;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_grants.size() == 0) begin
                    note_mismatch("result with no request pending", 0, o_status);
                end else begin
                    g = expected_grants.pop_front();
                    if (o_granted_slot !== g.slot) begin
                        note_mismatch("granted_slot", g.slot, o_granted_slot);
                    end
                    if (o_byte_offset !== g.offset) begin
                        note_mismatch("byte_offset", g.offset, o_byte_offset);
                    end
                    if (o_status !== g.status) begin
                        note_mismatch("status", g.status, o_status);
                    end
                end
            end
            if (start && !busy) begin
                predict_grant(i_func, i_release_slot);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SLOT_BYTES) begin
            cfg_bytes = data[BYTES_W-1:0];
        end else begin
            cfg_count = data[COUNT_W-1:0];
        end
    endtask

    task automatic add_req(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot);
        t_alloc_req r;
        r.func = func;
        r.slot = slot;
        pending_reqs.push_back(r);
        if (func != FUNC_NOP) begin
            random_sent++;
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_grants.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned n_reqs;
        int unsigned live;
        int unsigned r;
        logic [BYTES_W-1:0] new_bytes;
        logic [COUNT_W-1:0] new_count;

        cfg_bytes = SLOT_BYTES_RST;
        cfg_count = SLOT_COUNT_RST;
        rebuild_pool();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // reset chain, default config
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_FREE, 10'd1023);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_FREE, '0);
        add_req(FUNC_NOP, 10'h3ff);
        add_req(FUNC_ALLOC, '0);
        wait_idle();

        // empty pool after zero count
        reg_write(ADDR_SLOT_BYTES, 32'd4096);
        reg_write(ADDR_SLOT_COUNT, 32'd0);
        add_req(FUNC_REINIT, '0);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_FREE, '0);
        wait_idle();

        // clamped count, truncated offset, double free
        reg_write(ADDR_SLOT_BYTES, 32'd8191);
        reg_write(ADDR_SLOT_COUNT, 32'd2047);
        add_req(FUNC_REINIT, '0);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_FREE, 10'd1023);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_FREE, 10'd1);
        add_req(FUNC_FREE, 10'd1);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_ALLOC, '0);
        wait_idle();

        // single slot pool
        reg_write(ADDR_SLOT_BYTES, 32'd8);
        reg_write(ADDR_SLOT_COUNT, 32'd1);
        add_req(FUNC_REINIT, '0);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_ALLOC, '0);
        add_req(FUNC_FREE, '0);
        add_req(FUNC_FREE, 10'd1);
        add_req(FUNC_ALLOC, '0);
        wait_idle();

        random_sent = 0;
        live = 1;
        while (random_sent < RANDOM_REQS) begin
            case ($urandom_range(0, 5))
                0: new_bytes = 13'd8;
                1: new_bytes = 13'd4096;
                2: new_bytes = 13'd0;
                3: new_bytes = 13'd8191;
                default: new_bytes = BYTES_W'($urandom_range(8, 4096));
            endcase
            r = $urandom_range(0, 99);
            if (r < 60) begin
                new_count = COUNT_W'($urandom_range(1, 16));
            end else if (r < 68) begin
                new_count = '0;
            end else if (r < 80) begin
                new_count = COUNT_W'($urandom_range(17, 200));
            end else if (r < 87) begin
                new_count = COUNT_W'(MAX_SLOTS);
            end else if (r < 93) begin
                new_count = COUNT_W'($urandom_range(1025, 2047));
            end else begin
                new_count = COUNT_W'($urandom_range(0, 2047));
            end
            if ($urandom_range(0, 1)) begin
                reg_write(ADDR_SLOT_COUNT, DATA_W'(new_count));
                reg_write(ADDR_SLOT_BYTES, DATA_W'(new_bytes));
            end else begin
                reg_write(ADDR_SLOT_BYTES, DATA_W'(new_bytes));
                reg_write(ADDR_SLOT_COUNT, DATA_W'(new_count));
            end
            gap_mode = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) != 0) begin
                add_req(FUNC_REINIT, SLOT_W'($urandom));
                live = (new_count > MAX_SLOTS) ? MAX_SLOTS : new_count;
            end
            n_reqs = $urandom_range(30, 120);
            repeat (n_reqs) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    add_req(FUNC_ALLOC, SLOT_W'($urandom));
                end else if (r < 80) begin
                    if (live > 0) begin
                        add_req(FUNC_FREE, SLOT_W'($urandom_range(0, live - 1)));
                    end else begin
                        add_req(FUNC_FREE, SLOT_W'($urandom));
                    end
                end else if (r < 88) begin
                    add_req(FUNC_FREE, SLOT_W'($urandom));
                end else if (r < 94) begin
                    add_req(FUNC_REINIT, SLOT_W'($urandom));
                    live = (new_count > MAX_SLOTS) ? MAX_SLOTS : new_count;
                end else begin
                    add_req(FUNC_NOP, SLOT_W'($urandom));
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (expected_grants.size() != 0) begin
            note_mismatch("results left pending", 0, expected_grants.size());
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/fsa_pkg.sv
hdl/fsa_regs.sv
hdl/fsa_ctrl.sv
hdl/fsa_dp.sv
hdl/free_list_slot_allocator_unit.sv
verif/tb_free_list_slot_allocator_unit.sv
